// ===== rtl/tgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_pkg: shared types and constants of the text glyph decoder
// Token and group formats between the front and the back, and the result
// record carried to the output register.
// ----------------------------------------------------------------------------
package tgd_pkg;

  // Up to three glyphs can come out of one accepted byte.
  localparam int MAX_TOK = 3;

  localparam logic [6:0] QMARK = 7'd63;

  typedef enum logic [1:0] {
    TK_PLAIN,   // data[6:0] is the font character
    TK_LATIN,   // data is a code point to look up
    TK_HANZI    // data is the GB2312 byte pair {b1, b2}
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] data;
  } token_t;

  // All glyphs produced by one input item, oldest in tok[0].
  typedef struct packed {
    token_t [MAX_TOK-1:0] tok;
    logic [1:0]           count;
  } group_t;

  typedef struct packed {
    logic [2:0]  glyph_kind;
    logic [6:0]  base_char;
    logic [3:0]  accent_code;
    logic [1:0]  accent_raise;
    logic [13:0] hanzi_index;
    logic        bad_code;
    logic [1:0]  glyph_width;
    logic        last_of_run;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/tgd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_front: byte parser
// Joins held bytes with the new byte, splits them into glyph tokens and keeps
// the bytes of an unfinished sequence for the next item.
// ----------------------------------------------------------------------------
module tgd_front (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic text_mode,
  input  wire                logic push,
  output logic               full,
  input  wire                logic [7:0] text_byte,
  input  wire                logic end_of_text,
  input  wire                logic q_full,
  output logic               q_wr,
  output tgd_pkg::group_t    q_data
);
  import tgd_pkg::*;

  localparam logic [7:0] CP936_LEAD = 8'hA8;

  typedef struct packed {
    logic       stop;
    token_t     tok;
    logic [1:0] used;
  } step_t;

  logic [7:0] pend_byte [2];
  logic [1:0] pend_count;

  logic       accept;
  group_t     grp;
  logic [1:0] rem_count;
  logic [7:0] rem0;
  logic [7:0] rem1;

  function automatic logic [15:0] cp936_latin(input logic [7:0] b);
    logic [15:0] r;
    unique case (b)
      8'hA2:   r = 16'h00E1;
      8'hA4:   r = 16'h00E0;
      8'hA6:   r = 16'h00E9;
      8'hA8:   r = 16'h00E8;
      8'hAA:   r = 16'h00ED;
      8'hAC:   r = 16'h00EC;
      8'hAE:   r = 16'h00F3;
      8'hB0:   r = 16'h00F2;
      8'hB2:   r = 16'h00FA;
      8'hB4:   r = 16'h00F9;
      8'hB9:   r = 16'h00FC;
      8'hBA:   r = 16'h00EA;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // One glyph from the head of the byte window, or stop when the head
  // sequence still waits for bytes.
  function automatic step_t parse_one(input logic [7:0] c, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [1:0] n,
                                      input logic fin, input logic mode);
    step_t       s;
    logic [1:0]  need;
    logic [15:0] cp;
    s.stop      = 1'b0;
    s.used      = 2'd1;
    s.tok.kind  = TK_PLAIN;
    s.tok.data  = {9'd0, QMARK};
    cp          = cp936_latin(b1);
    if ((c >= 8'hC2 && c <= 8'hDF) || c == CP936_LEAD) need = 2'd2;
    else if (c >= 8'hE0 && c <= 8'hEF)                 need = 2'd3;
    else                                               need = 2'd1;
    priority if (!c[7]) begin
      s.tok.data = {8'd0, c};
    end else if (mode) begin
      if (n < 2'd2) begin
        s.stop = !fin;
      end else begin
        s.tok.kind = TK_HANZI;
        s.tok.data = {c, b1};
        s.used     = 2'd2;
      end
    end else if (need == 2'd1) begin
      s.stop = 1'b0;
    end else if (n < need) begin
      s.stop = !fin;
    end else if (c == CP936_LEAD) begin
      if (cp != 16'd0) begin
        s.tok.kind = TK_LATIN;
        s.tok.data = cp;
        s.used     = 2'd2;
      end
    end else if (need == 2'd2) begin
      if (b1[7:6] == 2'b10) begin
        s.tok.kind = TK_LATIN;
        s.tok.data = {5'd0, c[4:0], b1[5:0]};
        s.used     = 2'd2;
      end
    end else begin
      if (b1[7:6] == 2'b10 && b2[7:6] == 2'b10) begin
        s.tok.kind = TK_LATIN;
        s.tok.data = {c[3:0], b1[5:0], b2[5:0]};
        s.used     = 2'd3;
      end
    end
    return s;
  endfunction

  always_comb begin
    logic [7:0] win [3];
    logic [1:0] n;
    logic       stopped;
    step_t      s;
    win[0]  = text_byte;
    win[1]  = text_byte;
    win[2]  = text_byte;
    unique case (pend_count)
      2'd1: win[0] = pend_byte[0];
      2'd2: begin
        win[0] = pend_byte[0];
        win[1] = pend_byte[1];
      end
      default: ;
    endcase
    n       = pend_count + 2'd1;
    stopped = 1'b0;
    grp     = '0;
    s       = '0;
    for (int i = 0; i < MAX_TOK; i++) begin
      if (n != 2'd0 && !stopped) begin
        s = parse_one(win[0], win[1], win[2], n, end_of_text, text_mode);
        if (s.stop) begin
          stopped = 1'b1;
        end else begin
          grp.tok[i] = s.tok;
          grp.count  = 2'(i + 1);
          unique case (s.used)
            2'd1: begin
              win[0] = win[1];
              win[1] = win[2];
            end
            2'd2: win[0] = win[2];
            default: ;
          endcase
          n = n - s.used;
        end
      end
    end
    rem_count = n;
    rem0      = win[0];
    rem1      = win[1];
  end

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept && (grp.count != 2'd0);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
    end else if (accept) begin
      pend_count <= rem_count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_byte[0] <= rem0;
      pend_byte[1] <= rem1;
    end
  end

`ifndef SYNTH
  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    pend_count != 2'd3)
    else $error("held byte count out of range");

  a_end_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> pend_count == 2'd0)
    else $error("bytes still held after end of text");
`endif

endmodule
`default_nettype wire

// ===== rtl/tgd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_queue: token group queue
// Short first-in first-out store of token groups between parser and mapper.
// ----------------------------------------------------------------------------
module tgd_queue #(
  parameter int DEPTH = 4
) (
  input  wire             logic clk,
  input  wire             logic rst,
  input  wire             logic wr_en,
  input  wire tgd_pkg::group_t wr_data,
  output logic            full,
  input  wire             logic rd_en,
  output tgd_pkg::group_t rd_data,
  output logic            empty
);
  import tgd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full))
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && empty))
    else $error("read from empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/tgd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_back: glyph mapper
// Walks the head token group one token a cycle when output is free or popped,
// maps each token to a glyph descriptor and holds it in the output register.
// ----------------------------------------------------------------------------
module tgd_back (
  input  wire              logic clk,
  input  wire              logic rst,
  input  wire tgd_pkg::group_t q_data,
  input  wire              logic q_empty,
  output logic             q_rd,
  output tgd_pkg::result_t res,
  output logic             empty,
  input  wire              logic pop
);
  import tgd_pkg::*;

  localparam logic [2:0] GK_PLAIN     = 3'd0;
  localparam logic [2:0] GK_ACCENT    = 3'd1;
  localparam logic [2:0] GK_SHARP_S   = 3'd2;
  localparam logic [2:0] GK_DOTLESS_I = 3'd3;
  localparam logic [2:0] GK_HANZI     = 3'd4;

  localparam logic [3:0] AC_NONE   = 4'd0;
  localparam logic [3:0] AC_ACUTE  = 4'd1;
  localparam logic [3:0] AC_GRAVE  = 4'd2;
  localparam logic [3:0] AC_CIRC   = 4'd3;
  localparam logic [3:0] AC_TILDE  = 4'd4;
  localparam logic [3:0] AC_DIAER  = 4'd5;
  localparam logic [3:0] AC_RING   = 4'd6;
  localparam logic [3:0] AC_BREVE  = 4'd7;
  localparam logic [3:0] AC_CEDIL  = 4'd8;
  localparam logic [3:0] AC_DOT    = 4'd9;

  localparam logic [15:0] CP_SHARP_S   = 16'h00DF;
  localparam logic [15:0] CP_DOTLESS_I = 16'h0131;
  localparam logic [13:0] GB_ROW_LEN   = 14'd94;

  typedef struct packed {
    logic       found;
    logic [7:0] base;
    logic [3:0] accent;
  } latin_t;

  function automatic latin_t latin_lookup(input logic [15:0] cp);
    latin_t r;
    unique case (cp)
      16'h00C0: r = {1'b1, "A", AC_GRAVE};
      16'h00C1: r = {1'b1, "A", AC_ACUTE};
      16'h00C2: r = {1'b1, "A", AC_CIRC};
      16'h00C3: r = {1'b1, "A", AC_TILDE};
      16'h00C4: r = {1'b1, "A", AC_DIAER};
      16'h00C5: r = {1'b1, "A", AC_RING};
      16'h00E0: r = {1'b1, "a", AC_GRAVE};
      16'h00E1: r = {1'b1, "a", AC_ACUTE};
      16'h00E2: r = {1'b1, "a", AC_CIRC};
      16'h00E3: r = {1'b1, "a", AC_TILDE};
      16'h00E4: r = {1'b1, "a", AC_DIAER};
      16'h00E5: r = {1'b1, "a", AC_RING};
      16'h00C7: r = {1'b1, "C", AC_CEDIL};
      16'h00E7: r = {1'b1, "c", AC_CEDIL};
      16'h00C8: r = {1'b1, "E", AC_GRAVE};
      16'h00C9: r = {1'b1, "E", AC_ACUTE};
      16'h00CA: r = {1'b1, "E", AC_CIRC};
      16'h00CB: r = {1'b1, "E", AC_DIAER};
      16'h00E8: r = {1'b1, "e", AC_GRAVE};
      16'h00E9: r = {1'b1, "e", AC_ACUTE};
      16'h00EA: r = {1'b1, "e", AC_CIRC};
      16'h00EB: r = {1'b1, "e", AC_DIAER};
      16'h00CC: r = {1'b1, "I", AC_GRAVE};
      16'h00CD: r = {1'b1, "I", AC_ACUTE};
      16'h00CE: r = {1'b1, "I", AC_CIRC};
      16'h00CF: r = {1'b1, "I", AC_DIAER};
      16'h00EC: r = {1'b1, "i", AC_GRAVE};
      16'h00ED: r = {1'b1, "i", AC_ACUTE};
      16'h00EE: r = {1'b1, "i", AC_CIRC};
      16'h00EF: r = {1'b1, "i", AC_DIAER};
      16'h00D1: r = {1'b1, "N", AC_TILDE};
      16'h00F1: r = {1'b1, "n", AC_TILDE};
      16'h00D2: r = {1'b1, "O", AC_GRAVE};
      16'h00D3: r = {1'b1, "O", AC_ACUTE};
      16'h00D4: r = {1'b1, "O", AC_CIRC};
      16'h00D5: r = {1'b1, "O", AC_TILDE};
      16'h00D6: r = {1'b1, "O", AC_DIAER};
      16'h00F2: r = {1'b1, "o", AC_GRAVE};
      16'h00F3: r = {1'b1, "o", AC_ACUTE};
      16'h00F4: r = {1'b1, "o", AC_CIRC};
      16'h00F5: r = {1'b1, "o", AC_TILDE};
      16'h00F6: r = {1'b1, "o", AC_DIAER};
      16'h00D9: r = {1'b1, "U", AC_GRAVE};
      16'h00DA: r = {1'b1, "U", AC_ACUTE};
      16'h00DB: r = {1'b1, "U", AC_CIRC};
      16'h00DC: r = {1'b1, "U", AC_DIAER};
      16'h00F9: r = {1'b1, "u", AC_GRAVE};
      16'h00FA: r = {1'b1, "u", AC_ACUTE};
      16'h00FB: r = {1'b1, "u", AC_CIRC};
      16'h00FC: r = {1'b1, "u", AC_DIAER};
      16'h00DD: r = {1'b1, "Y", AC_ACUTE};
      16'h00FD: r = {1'b1, "y", AC_ACUTE};
      16'h00FF: r = {1'b1, "y", AC_DIAER};
      16'h011E: r = {1'b1, "G", AC_BREVE};
      16'h011F: r = {1'b1, "g", AC_BREVE};
      16'h0130: r = {1'b1, "I", AC_DOT};
      16'h015E: r = {1'b1, "S", AC_CEDIL};
      16'h015F: r = {1'b1, "s", AC_CEDIL};
      default:  r = {1'b0, 8'd0, AC_NONE};
    endcase
    return r;
  endfunction

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       last;
  token_t     tok;
  latin_t     lat;
  result_t    res_next;

  logic [7:0] hz_b1;
  logic [7:0] hz_b2;
  logic       hz_ok;
  logic [6:0] hz_row;
  logic [6:0] hz_col;

  assign tok   = q_data.tok[idx];
  assign last  = (idx == q_data.count - 2'd1);
  assign load  = !q_empty && (!out_valid || pop);
  assign q_rd  = load && last;
  assign empty = !out_valid;
  assign lat   = latin_lookup(tok.data);

  assign hz_b1  = tok.data[15:8];
  assign hz_b2  = tok.data[7:0];
  assign hz_ok  = ((hz_b1 >= 8'hA1 && hz_b1 <= 8'hA9) || (hz_b1 >= 8'hB0 && hz_b1 <= 8'hF7))
                  && (hz_b2 >= 8'hA1 && hz_b2 <= 8'hFE);
  // rows from B0 follow the nine symbol rows
  assign hz_row = (hz_b1 < 8'hB0) ? 7'(hz_b1 - 8'hA1) : 7'(hz_b1 - 8'hB0 + 8'd9);
  assign hz_col = 7'(hz_b2 - 8'hA1);

  always_comb begin
    res_next              = '0;
    res_next.glyph_kind   = GK_PLAIN;
    res_next.accent_code  = AC_NONE;
    res_next.glyph_width  = 2'd1;
    res_next.last_of_run  = last;
    unique case (tok.kind)
      TK_PLAIN: res_next.base_char = tok.data[6:0];
      TK_LATIN: begin
        priority if (tok.data == CP_SHARP_S) begin
          res_next.glyph_kind = GK_SHARP_S;
        end else if (tok.data == CP_DOTLESS_I) begin
          res_next.glyph_kind = GK_DOTLESS_I;
        end else if (lat.found) begin
          res_next.glyph_kind  = GK_ACCENT;
          res_next.base_char   = lat.base[6:0];
          res_next.accent_code = lat.accent;
          if (lat.accent == AC_DIAER && (lat.base == "a" || lat.base == "e" ||
              lat.base == "i" || lat.base == "o" || lat.base == "u" || lat.base == "y")) begin
            res_next.accent_raise = 2'd2;
          end else if (lat.accent == AC_BREVE && lat.base == "g") begin
            res_next.accent_raise = 2'd1;
          end
        end else begin
          res_next.base_char = QMARK;
        end
      end
      TK_HANZI: begin
        res_next.glyph_kind  = GK_HANZI;
        res_next.glyph_width = 2'd2;
        if (hz_ok) begin
          res_next.hanzi_index = 14'(hz_row) * GB_ROW_LEN + 14'(hz_col);
        end else begin
          res_next.bad_code = 1'b1;
        end
      end
      default: res_next.base_char = QMARK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? 2'd0 : idx + 2'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

`ifndef SYNTH
  a_idx_rewind: assert property (@(posedge clk) disable iff (rst)
    q_rd |=> idx == 2'd0)
    else $error("token index not rewound after group");

  a_group_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.last_of_run) |-> !q_empty)
    else $error("group left queue before its last glyph");
`endif

endmodule
`default_nettype wire

// ===== rtl/text_glyph_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_glyph_decoder_unit: text byte to glyph descriptor decoder
// Latin UTF-8 / cp936 accent pairs or GB2312 double-byte text in, one glyph
// descriptor per shown character out.
//
//   channel   handshake              payload
//   input     push / full            text_byte, end_of_text
//   result    pop / empty            glyph_kind .. last_of_run
//   config    cfg_valid / cfg_ready  cfg_data (text mode)
//
// One byte is accepted each cycle while the token queue has room; the parser
// resolves up to three glyphs from a byte in the same cycle.
// Results leave at one per cycle from the output register while popped, and a
// byte's glyphs pass the mapper one after another; the queue absorbs bursts.
// Glyphs pass the token queue, then the output register, to the result ports.
// Reset clears held bytes, the queue and the output register; cfg_ready is high.
// ----------------------------------------------------------------------------
module text_glyph_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        cfg_valid,
  output logic              cfg_ready,
  input  wire  logic        cfg_data,
  input  wire  logic        push,
  output logic              full,
  input  wire  logic [7:0]  text_byte,
  input  wire  logic        end_of_text,
  input  wire  logic        pop,
  output logic              empty,
  output logic [2:0]        glyph_kind,
  output logic [6:0]        base_char,
  output logic [3:0]        accent_code,
  output logic [1:0]        accent_raise,
  output logic [13:0]       hanzi_index,
  output logic              bad_code,
  output logic [1:0]        glyph_width,
  output logic              last_of_run
);
  import tgd_pkg::*;

  logic    text_mode;
  logic    q_wr;
  logic    q_rd;
  logic    q_full;
  logic    q_empty;
  group_t  q_wr_data;
  group_t  q_rd_data;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      text_mode <= cfg_data;
    end
  end

  tgd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_mode   (text_mode),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_data      (q_wr_data)
  );

  tgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  tgd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rd_data),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign glyph_kind   = res.glyph_kind;
  assign base_char    = res.base_char;
  assign accent_code  = res.accent_code;
  assign accent_raise = res.accent_raise;
  assign hanzi_index  = res.hanzi_index;
  assign bad_code     = res.bad_code;
  assign glyph_width  = res.glyph_width;
  assign last_of_run  = res.last_of_run;

endmodule
`default_nettype wire
